[rtl/core/rxs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rxs_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RateW  = 31;
  localparam int unsigned RadixW = 5;
  localparam int unsigned CarryW = 30;
  localparam int unsigned CfgW   = 32;

  localparam logic [RadixW-1:0] RadixLimit = 5'd30;
  localparam logic [DataW-1:0]  Q31Max     = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0]  Q31Min     = 32'h8000_0000;

  typedef enum logic [0:0] {
    CFG_RATE  = 1'b0,
    CFG_RADIX = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [RateW-1:0]  rate;
    logic [RadixW-1:0] radix;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/radix_exponential_slew.sv]
`timescale 1ns / 1ps
`default_nettype none

// One-pole exponential smoother: each target transfer moves the held Q31 value
// towards the target by rate times the remaining distance, carrying the low
// radix bits of the step forward so small steps are not lost. One item is taken
// every cycle while the output is not stalled; each target is captured in the
// input register, then the state/result register takes the stepped result. The
// rate is set by the state update loop, which passes through the 31x31 multiplier
// once per item. rate and radix are to be written through the cfg port only while
// the stream is idle; the block itself does not enforce this. Radix values above
// 30 are held at 30. Value and carry reset to zero.
module radix_exponential_slew
  import rxs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,

  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [DataW-1:0] s_axis_tdata,   // [31:0] target

  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [DataW-1:0] m_axis_tdata,   // [31:0] smoothed

  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [0:0]       cfg_index_i,
  input  wire logic [CfgW-1:0]  cfg_data_i
);

  cfg_t              cfg;
  logic              in_valid_q, in_valid_d;
  logic [DataW-1:0]  in_target_q;
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  cur_q, cur_d;
  logic [CarryW-1:0] carry_q, carry_d;
  logic [DataW-1:0]  step_cur;
  logic [CarryW-1:0] step_carry;
  logic              advance;

  rxs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rxs_step u_step (
    .cfg_i    (cfg),
    .target_i (in_target_q),
    .cur_i    (cur_q),
    .carry_i  (carry_q),
    .cur_o    (step_cur),
    .carry_o  (step_carry)
  );

  // the held value doubles as the result register: it only changes when the
  // result slot is free to take the next one
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    cur_d       = cur_q;
    carry_d     = carry_q;
    if (advance) begin
      out_valid_d = in_valid_q;
      if (in_valid_q) begin
        cur_d   = step_cur;
        carry_d = step_carry;
      end
    end
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      carry_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      carry_q     <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_target_q <= s_axis_tdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = cur_q;

endmodule

`default_nettype wire

[rtl/core/rxs_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module rxs_cfg
  import rxs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [0:0]      cfg_index_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic [RadixW-1:0] radix_in;

  assign cfg_ready_o = 1'b1;
  // radix beyond the usable range clamps to the limit
  assign radix_in = (cfg_data_i[RadixW-1:0] > RadixLimit) ? RadixLimit
                                                          : cfg_data_i[RadixW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RATE:  cfg_d.rate  = cfg_data_i[RateW-1:0];
        CFG_RADIX: cfg_d.radix = radix_in;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/rxs_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module rxs_step
  import rxs_pkg::*;
(
  input  cfg_t                   cfg_i,
  input  wire logic [DataW-1:0]  target_i,
  input  wire logic [DataW-1:0]  cur_i,
  input  wire logic [CarryW-1:0] carry_i,
  output logic      [DataW-1:0]  cur_o,
  output logic      [CarryW-1:0] carry_o
);

  logic [DataW:0]         diff;
  logic [DataW:0]         diff_abs;
  logic                   diff_neg;
  logic                   diff_zero;
  logic [RateW-1:0]       mag;
  logic [2*RateW-1:0]     mag_wide;
  logic [RateW-1:0]       shifted;
  logic [2*RateW-1:0]     prod_full;
  logic [RateW-1:0]       prod;
  logic [DataW-1:0]       sum_raw;
  logic [RateW-1:0]       sum;
  logic [CarryW-1:0]      carry_mask;
  logic [RateW-1:0]       inc;
  logic [DataW:0]         nxt_raw;

  always_comb begin
    diff      = {target_i[DataW-1], target_i} - {cur_i[DataW-1], cur_i};
    diff_neg  = diff[DataW];
    diff_zero = (diff == '0);
    diff_abs  = diff_neg ? (~diff + 1'b1) : diff;
    // full-scale distance saturates to Q31 max
    mag       = diff_abs[DataW-1] ? Q31Max[RateW-1:0] : diff_abs[RateW-1:0];

    mag_wide  = {{RateW{1'b0}}, mag} << cfg_i.radix;
    shifted   = (mag_wide[2*RateW-1:RateW] != '0) ? Q31Max[RateW-1:0]
                                                  : mag_wide[RateW-1:0];

    // Q31 product: drop the low 31 bits
    prod_full = shifted * cfg_i.rate;
    prod      = prod_full[2*RateW-1:RateW];

    sum_raw   = {1'b0, prod} + {{(DataW-CarryW){1'b0}}, carry_i};
    sum       = sum_raw[DataW-1] ? Q31Max[RateW-1:0] : sum_raw[RateW-1:0];

    carry_mask = ~({CarryW{1'b1}} << cfg_i.radix);
    carry_o    = sum[CarryW-1:0] & carry_mask;
    inc        = sum >> cfg_i.radix;

    if (diff_neg) begin
      nxt_raw = {cur_i[DataW-1], cur_i} - {2'b00, inc};
    end else begin
      nxt_raw = {cur_i[DataW-1], cur_i} + {2'b00, inc};
    end

    if (diff_zero) begin
      cur_o = cur_i;
    end else begin
      unique case (nxt_raw[DataW:DataW-1])
        2'b01:   cur_o = Q31Max;
        2'b10:   cur_o = Q31Min;
        default: cur_o = nxt_raw[DataW-1:0];
      endcase
    end
  end

endmodule

`default_nettype wire
